// File: rtl/olid_pkg.sv
// shared types, constants and helpers for the ordered list block
// no dependencies; used by olid_ctrl, olid_dp and ordered_list_insert_delete_top
package olid_pkg;

	localparam int CAPACITY    = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int POS_W       = 6;
	localparam int LEN_W       = 6;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic [VALUE_WIDTH-1:0] val_t;

	localparam logic [2:0] ACT_INS_AT    = 3'd0;
	localparam logic [2:0] ACT_DEL_AT    = 3'd1;
	localparam logic [2:0] ACT_INS_MATCH = 3'd2;
	localparam logic [2:0] ACT_DEL_MATCH = 3'd3;
	localparam logic [2:0] ACT_CLEAR     = 3'd4;
	localparam logic [2:0] ACT_DUMP      = 3'd5;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef enum logic [2:0] {
		MV_INS_UP,
		MV_DEL_DOWN,
		MV_SEARCH,
		MV_COMPACT,
		MV_DUMP
	} mv_kind_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [POS_W-1:0]   position;
		logic signed [31:0] new_value;
		logic signed [31:0] match_key;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [LEN_W-1:0]   length;
		logic signed [31:0] entry_value;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       mv_start;
		mv_kind_t   mv_kind;
		logic       rd_step;
		logic       fin_ins;
		logic       fin_del;
		logic       fin_compact;
		logic       clr;
		logic       out_load;
		logic [1:0] out_status;
		logic       out_entry;
		logic       out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic       full;
		logic       empty;
		logic       ins_pos_ok;
		logic       del_pos_ok;
		logic       mv_busy;
		logic       found;
		logic       compact_hit;
		logic       dump_last;
		logic       out_free;
	} dp_sts_t;

	// wrap a 32-bit input word to the stored width
	function automatic val_t to_val(input logic [31:0] x);
		val_t r;
		for (int b = 0; b < VALUE_WIDTH; b++)
			r[b] = x[(b < 32) ? b : 31];
		return r;
	endfunction

	// sign-extend a stored value, then cut to 32 bits
	function automatic logic [31:0] to_out(input val_t v);
		logic [31:0] r;
		for (int b = 0; b < 32; b++)
			r[b] = v[(b < VALUE_WIDTH) ? b : VALUE_WIDTH - 1];
		return r;
	endfunction

	// entry count reported modulo 64
	function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
		logic [LEN_W-1:0] r;
		for (int b = 0; b < LEN_W; b++)
			r[b] = (b < CNT_W) ? c[(b < CNT_W) ? b : 0] : 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/olid_dp.sv
// datapath of the ordered list: entry memory, move engine, count and result register
// depends on olid_pkg
module olid_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  olid_pkg::req_t    req,
	input  olid_pkg::dp_cmd_t cmd,
	output olid_pkg::dp_sts_t sts,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output olid_pkg::rsp_t    rsp
);

	logic [olid_pkg::CNT_W-1:0] cnt_q;
	logic [olid_pkg::CNT_W-1:0] rem_q;
	logic [olid_pkg::CNT_W-1:0] dst_q;
	logic [olid_pkg::IDX_W-1:0] src_q;
	logic [olid_pkg::IDX_W-1:0] ridx_s1;
	logic [olid_pkg::IDX_W-1:0] fidx_q;
	logic                       dir_up_q;
	olid_pkg::mv_kind_t         kind_q;
	logic                       rd_v_s1;
	olid_pkg::val_t             rdata_s1;
	logic                       found_q;
	olid_pkg::req_t             item_q;
	olid_pkg::val_t             val_q;
	olid_pkg::val_t             key_q;
	olid_pkg::val_t             mem_q [olid_pkg::CAPACITY];
	olid_pkg::rsp_t             rsp_q;
	logic                       rsp_valid_q;

	logic [olid_pkg::CMP_W-1:0] pos_ext;
	logic [olid_pkg::CMP_W-1:0] cnt_ext;
	logic [olid_pkg::CNT_W-1:0] pos_c;
	logic [olid_pkg::CNT_W-1:0] pos_p1;
	logic [olid_pkg::CNT_W-1:0] cnt_m1;
	logic [olid_pkg::CNT_W-1:0] ins_pos;
	logic                       mv_busy;
	logic                       issue;
	logic                       hit;
	logic                       mv_wr;
	logic                       out_free;

	assign pos_ext  = olid_pkg::CMP_W'(item_q.position);
	assign cnt_ext  = olid_pkg::CMP_W'(cnt_q);
	assign pos_c    = olid_pkg::CNT_W'(item_q.position);
	assign pos_p1   = pos_c + olid_pkg::CNT_W'(1);
	assign cnt_m1   = cnt_q - olid_pkg::CNT_W'(1);
	// insert after a match lands right behind the matching entry
	assign ins_pos  = (item_q.action == olid_pkg::ACT_INS_MATCH) ?
		(olid_pkg::CNT_W'(fidx_q) + olid_pkg::CNT_W'(1)) : pos_c;
	assign mv_busy  = (rem_q != '0) || rd_v_s1;
	assign issue    = cmd.rd_step && (rem_q != '0);
	assign hit      = (rdata_s1 == key_q);
	assign mv_wr    = rd_v_s1 && ((kind_q == olid_pkg::MV_INS_UP) ||
		(kind_q == olid_pkg::MV_DEL_DOWN) || ((kind_q == olid_pkg::MV_COMPACT) && !hit));
	assign out_free = !rsp_valid_q || rsp_ready;

	assign sts.action      = item_q.action;
	assign sts.full        = (cnt_q >= olid_pkg::CNT_W'(olid_pkg::CAPACITY));
	assign sts.empty       = (cnt_q == '0);
	assign sts.ins_pos_ok  = (pos_ext <= cnt_ext);
	assign sts.del_pos_ok  = (pos_ext < cnt_ext);
	assign sts.mv_busy     = mv_busy;
	assign sts.found       = found_q;
	assign sts.compact_hit = (dst_q != cnt_q);
	assign sts.dump_last   = (rem_q == '0);
	assign sts.out_free    = out_free;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rem_q       <= '0;
			rd_v_s1     <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			if (cmd.mv_start) begin
				found_q <= 1'b0;
				unique case (cmd.mv_kind)
					olid_pkg::MV_INS_UP:   rem_q <= cnt_q - ins_pos;
					olid_pkg::MV_DEL_DOWN: rem_q <= cnt_m1 - pos_c;
					default:               rem_q <= cnt_q;
				endcase
			end else begin
				if (issue)
					rem_q <= rem_q - olid_pkg::CNT_W'(1);
				if (rd_v_s1 && (kind_q == olid_pkg::MV_SEARCH) && hit)
					found_q <= 1'b1;
			end
			priority if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.fin_ins) begin
				cnt_q <= cnt_q + olid_pkg::CNT_W'(1);
			end else if (cmd.fin_del) begin
				cnt_q <= cnt_m1;
			end else if (cmd.fin_compact) begin
				cnt_q <= dst_q;
			end
			if (cmd.out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= req;
			val_q  <= olid_pkg::to_val(req.new_value);
			key_q  <= olid_pkg::to_val(req.match_key);
		end
		if (cmd.mv_start) begin
			kind_q <= cmd.mv_kind;
			unique case (cmd.mv_kind)
				olid_pkg::MV_INS_UP: begin
					src_q    <= cnt_m1[olid_pkg::IDX_W-1:0];
					dst_q    <= cnt_q;
					dir_up_q <= 1'b0;
				end
				olid_pkg::MV_DEL_DOWN: begin
					src_q    <= pos_p1[olid_pkg::IDX_W-1:0];
					dst_q    <= pos_c;
					dir_up_q <= 1'b1;
				end
				default: begin
					src_q    <= '0;
					dst_q    <= '0;
					dir_up_q <= 1'b1;
				end
			endcase
		end else begin
			if (issue)
				src_q <= dir_up_q ? (src_q + olid_pkg::IDX_W'(1)) :
					(src_q - olid_pkg::IDX_W'(1));
			if (mv_wr)
				dst_q <= dir_up_q ? (dst_q + olid_pkg::CNT_W'(1)) :
					(dst_q - olid_pkg::CNT_W'(1));
			// keep only the first match
			if (rd_v_s1 && (kind_q == olid_pkg::MV_SEARCH) && hit && !found_q)
				fidx_q <= ridx_s1;
		end
		if (issue) begin
			rdata_s1 <= mem_q[src_q];
			ridx_s1  <= src_q;
		end
		if (cmd.fin_ins)
			mem_q[ins_pos[olid_pkg::IDX_W-1:0]] <= val_q;
		else if (mv_wr)
			mem_q[dst_q[olid_pkg::IDX_W-1:0]] <= rdata_s1;
		if (cmd.out_load) begin
			rsp_q.status      <= cmd.out_status;
			rsp_q.length      <= olid_pkg::len_of(cnt_q);
			rsp_q.entry_value <= cmd.out_entry ? olid_pkg::to_out(rdata_s1) : '0;
			rsp_q.last        <= cmd.out_last;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= olid_pkg::CNT_W'(olid_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_start_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mv_start |-> (rem_q == '0 && !rd_v_s1))
		else $error("move started while engine busy");

	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fin_ins || cmd.fin_compact || cmd.fin_del) |-> !mv_busy)
		else $error("finish step while moves in flight");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result register overwritten");
`endif

endmodule

// File: rtl/olid_ctrl.sv
// controller state machine of the ordered list: decodes the action and sequences the datapath
// depends on olid_pkg
module olid_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  olid_pkg::dp_sts_t sts,
	output olid_pkg::dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MOVE,
		S_SEARCH,
		S_FIN,
		S_DMP_RD,
		S_DMP_OUT,
		S_RESP
	} state_t;

	state_t     state_q;
	state_t     state_n;
	logic [1:0] st_q;
	logic [1:0] st_n;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		st_n    = st_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = req_valid;
				if (req_valid)
					state_n = S_CHECK;
			end
			S_CHECK: begin
				unique case (sts.action)
					olid_pkg::ACT_INS_AT: begin
						// fullness is checked before the position
						if (sts.full) begin
							st_n    = olid_pkg::ST_FULL;
							state_n = S_RESP;
						end else if (!sts.ins_pos_ok) begin
							st_n    = olid_pkg::ST_BAD;
							state_n = S_RESP;
						end else begin
							cmd.mv_start = 1'b1;
							cmd.mv_kind  = olid_pkg::MV_INS_UP;
							state_n      = S_MOVE;
						end
					end
					olid_pkg::ACT_DEL_AT: begin
						if (!sts.del_pos_ok) begin
							st_n    = olid_pkg::ST_BAD;
							state_n = S_RESP;
						end else begin
							cmd.mv_start = 1'b1;
							cmd.mv_kind  = olid_pkg::MV_DEL_DOWN;
							state_n      = S_MOVE;
						end
					end
					olid_pkg::ACT_INS_MATCH: begin
						if (sts.full) begin
							st_n    = olid_pkg::ST_FULL;
							state_n = S_RESP;
						end else begin
							cmd.mv_start = 1'b1;
							cmd.mv_kind  = olid_pkg::MV_SEARCH;
							state_n      = S_SEARCH;
						end
					end
					olid_pkg::ACT_DEL_MATCH: begin
						if (sts.empty) begin
							st_n    = olid_pkg::ST_BAD;
							state_n = S_RESP;
						end else begin
							cmd.mv_start = 1'b1;
							cmd.mv_kind  = olid_pkg::MV_COMPACT;
							state_n      = S_MOVE;
						end
					end
					olid_pkg::ACT_CLEAR: begin
						cmd.clr = 1'b1;
						st_n    = olid_pkg::ST_OK;
						state_n = S_RESP;
					end
					olid_pkg::ACT_DUMP: begin
						// empty dump still gives one word
						if (sts.empty) begin
							st_n    = olid_pkg::ST_OK;
							state_n = S_RESP;
						end else begin
							cmd.mv_start = 1'b1;
							cmd.mv_kind  = olid_pkg::MV_DUMP;
							state_n      = S_DMP_RD;
						end
					end
					default: begin
						st_n    = olid_pkg::ST_BAD;
						state_n = S_RESP;
					end
				endcase
			end
			S_MOVE: begin
				cmd.rd_step = 1'b1;
				if (!sts.mv_busy)
					state_n = S_FIN;
			end
			S_SEARCH: begin
				cmd.rd_step = 1'b1;
				if (!sts.mv_busy) begin
					if (sts.found) begin
						cmd.mv_start = 1'b1;
						cmd.mv_kind  = olid_pkg::MV_INS_UP;
						state_n      = S_MOVE;
					end else begin
						st_n    = olid_pkg::ST_MISSING;
						state_n = S_RESP;
					end
				end
			end
			S_FIN: begin
				state_n = S_RESP;
				unique case (sts.action)
					olid_pkg::ACT_INS_AT, olid_pkg::ACT_INS_MATCH: begin
						cmd.fin_ins = 1'b1;
						st_n        = olid_pkg::ST_OK;
					end
					olid_pkg::ACT_DEL_AT: begin
						cmd.fin_del = 1'b1;
						st_n        = olid_pkg::ST_OK;
					end
					olid_pkg::ACT_DEL_MATCH: begin
						cmd.fin_compact = 1'b1;
						st_n = sts.compact_hit ? olid_pkg::ST_OK : olid_pkg::ST_MISSING;
					end
					default: begin
						st_n = olid_pkg::ST_BAD;
					end
				endcase
			end
			S_DMP_RD: begin
				cmd.rd_step = 1'b1;
				state_n     = S_DMP_OUT;
			end
			S_DMP_OUT: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = olid_pkg::ST_OK;
					cmd.out_entry  = 1'b1;
					cmd.out_last   = sts.dump_last;
					state_n        = sts.dump_last ? S_IDLE : S_DMP_RD;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = st_q;
					cmd.out_last   = 1'b1;
					state_n        = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q    <= olid_pkg::ST_OK;
		end else begin
			state_q <= state_n;
			st_q    <= st_n;
		end
	end

endmodule

// File: rtl/ordered_list_insert_delete_top.sv
// ordered list top: one word in, one result word out, or a run of words for a dump
// status-only actions load the result register after the action check; other actions
// shift, search or compact entries first; insert after match scans, then shifts; dump:
// each entry is read, then loaded into the result register when it is free
// one word is worked on at a time; reset empties the list, no memory clearing pass
// depends on olid_pkg, olid_ctrl, olid_dp
module ordered_list_insert_delete_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  olid_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output olid_pkg::rsp_t rsp
);

	olid_pkg::dp_cmd_t cmd;
	olid_pkg::dp_sts_t sts;

	olid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	olid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
